// ===== sv/rmfh_pkg.sv =====
`timescale 1ns / 1ps

package rmfh_pkg;

   localparam int TID_W    = 8;
   localparam int DEPTH_W  = 8;
   localparam int STATUS_W = 4;

   localparam int WAIT_SLOTS_DEFAULT = 16;
   localparam int MAX_NEST_DEFAULT   = 255;

   typedef enum logic {
      CMD_ACQUIRE = 1'b0,
      CMD_RELEASE = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED    = 4'd0,
      ST_NESTED     = 4'd1,
      ST_QUEUED     = 4'd2,
      ST_UNNESTED   = 4'd3,
      ST_FREED      = 4'd4,
      ST_HANDOFF    = 4'd5,
      ST_DEPTH_ERR  = 4'd6,
      ST_NOT_HOLDER = 4'd7,
      ST_QUEUE_FULL = 4'd8
   } status_type;

endpackage

// ===== sv/rmfh_wait_ram.sv =====
`timescale 1ns / 1ps

module rmfh_wait_ram #(
   parameter int DEPTH  = rmfh_pkg::WAIT_SLOTS_DEFAULT,
   parameter int ADDR_W = $clog2(rmfh_pkg::WAIT_SLOTS_DEFAULT)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [rmfh_pkg::TID_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [rmfh_pkg::TID_W-1:0] rd_data
);

   logic [rmfh_pkg::TID_W-1:0] mem [DEPTH];
   logic [rmfh_pkg::TID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/recursive_mutex_fifo_handoff.sv =====
`timescale 1ns / 1ps

// Lock unit for one recursive mutex with a first-in, first-out wait queue. A transaction is
// taken at a clock edge where start is high and busy is low; busy then stays high while the
// block decides, and the result appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, from the edge at which busy falls. The receiver cannot stall and must capture the result in
// that cycle. The block takes no new transaction while busy: the wait-queue memory is read
// at the head slot when the transaction is taken, and its registered data is needed for a
// hand-off before the holder, depth and queue can be updated in the decision cycle. Queue
// slots are never cleared; the head slot is read on every accepted transaction, but its data
// is used only when it holds a waiter. recursive_mode may be written only while the block is idle.
module recursive_mutex_fifo_handoff #(
   parameter int WAIT_SLOTS = rmfh_pkg::WAIT_SLOTS_DEFAULT,
   parameter int MAX_NEST   = rmfh_pkg::MAX_NEST_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [rmfh_pkg::TID_W-1:0]    req_thread_id,
   output logic                          rsp_valid,
   output logic [rmfh_pkg::STATUS_W-1:0] rsp_status,
   output logic [rmfh_pkg::TID_W-1:0]    rsp_granted_thread,
   output logic                          rsp_holder_valid,
   output logic [rmfh_pkg::DEPTH_W-1:0]  rsp_depth,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data
);

   localparam int PTR_W = $clog2(WAIT_SLOTS);
   localparam int CNT_W = $clog2(WAIT_SLOTS + 1);
   localparam logic [CNT_W-1:0] SlotCount = CNT_W'(WAIT_SLOTS);
   localparam logic [PTR_W-1:0] LastSlot  = PTR_W'(WAIT_SLOTS - 1);
   localparam logic [rmfh_pkg::DEPTH_W-1:0] MaxNestDepth = rmfh_pkg::DEPTH_W'(MAX_NEST);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type                     state_ff;
   logic                          recursive_ff;
   logic                          present_ff, present_in;
   logic [rmfh_pkg::TID_W-1:0]    holder_ff, holder_in;
   logic [rmfh_pkg::DEPTH_W-1:0]  depth_ff, depth_in;
   logic [PTR_W-1:0]              head_ff, head_in;
   logic [PTR_W-1:0]              tail_ff, tail_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          rsp_valid_ff;

   rmfh_pkg::command_type         cmd_ff;
   logic [rmfh_pkg::TID_W-1:0]    tid_ff;
   rmfh_pkg::status_type          status_in, status_ff;
   logic [rmfh_pkg::TID_W-1:0]    granted_ff;
   logic                          holder_valid_ff;
   logic [rmfh_pkg::DEPTH_W-1:0]  rsp_depth_ff;

   logic                          accept;
   logic                          exec;
   logic                          push;
   logic [rmfh_pkg::TID_W-1:0]    head_tid;
   logic [rmfh_pkg::DEPTH_W-1:0]  depth_limit;
   logic [PTR_W-1:0]              head_next;
   logic [PTR_W-1:0]              tail_next;

   assign accept = start && (state_ff == S_IDLE);
   assign exec   = (state_ff == S_EXEC);
   assign busy   = exec;

   assign depth_limit = recursive_ff ? MaxNestDepth : rmfh_pkg::DEPTH_W'(1);
   assign head_next   = (head_ff == LastSlot) ? '0 : head_ff + PTR_W'(1);
   assign tail_next   = (tail_ff == LastSlot) ? '0 : tail_ff + PTR_W'(1);

   // The head slot is read when the transaction is taken, so its data is ready for the
   // decision cycle. Pushes are written at the end of the decision cycle, before the next read.
   rmfh_wait_ram #(
      .DEPTH  (WAIT_SLOTS),
      .ADDR_W (PTR_W)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (tid_ff),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (head_tid)
   );

   always_comb begin
      present_in = present_ff;
      holder_in  = holder_ff;
      depth_in   = depth_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      push       = 1'b0;
      status_in  = rmfh_pkg::ST_NOT_HOLDER;
      case (cmd_ff)
         rmfh_pkg::CMD_ACQUIRE: begin
            if (!present_ff) begin
               present_in = 1'b1;
               holder_in  = tid_ff;
               depth_in   = rmfh_pkg::DEPTH_W'(1);
               status_in  = rmfh_pkg::ST_GRANTED;
            end else if (holder_ff == tid_ff) begin
               if (depth_ff >= depth_limit) begin
                  status_in = rmfh_pkg::ST_DEPTH_ERR;
               end else begin
                  depth_in  = depth_ff + rmfh_pkg::DEPTH_W'(1);
                  status_in = rmfh_pkg::ST_NESTED;
               end
            end else if (count_ff == SlotCount) begin
               status_in = rmfh_pkg::ST_QUEUE_FULL;
            end else begin
               push      = exec;
               tail_in   = tail_next;
               count_in  = count_ff + CNT_W'(1);
               status_in = rmfh_pkg::ST_QUEUED;
            end
         end
         rmfh_pkg::CMD_RELEASE: begin
            if (!present_ff || (holder_ff != tid_ff)) begin
               status_in = rmfh_pkg::ST_NOT_HOLDER;
            end else if (depth_ff > rmfh_pkg::DEPTH_W'(1)) begin
               depth_in  = depth_ff - rmfh_pkg::DEPTH_W'(1);
               status_in = rmfh_pkg::ST_UNNESTED;
            end else if (count_ff != '0) begin
               holder_in = head_tid;
               head_in   = head_next;
               count_in  = count_ff - CNT_W'(1);
               depth_in  = rmfh_pkg::DEPTH_W'(1);
               status_in = rmfh_pkg::ST_HANDOFF;
            end else begin
               present_in = 1'b0;
               holder_in  = '0;
               depth_in   = '0;
               status_in  = rmfh_pkg::ST_FREED;
            end
         end
         default: begin
            status_in = rmfh_pkg::ST_NOT_HOLDER;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         recursive_ff <= 1'b0;
         present_ff   <= 1'b0;
         holder_ff    <= '0;
         depth_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_write_enable) begin
            recursive_ff <= csr_write_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff        <= S_IDLE;
               rsp_valid_ff    <= 1'b1;
               present_ff      <= present_in;
               holder_ff       <= holder_in;
               depth_ff        <= depth_in;
               head_ff         <= head_in;
               tail_ff         <= tail_in;
               count_ff        <= count_in;
               status_ff       <= status_in;
               holder_valid_ff <= present_in;
               granted_ff      <= present_in ? holder_in : '0;
               rsp_depth_ff    <= present_in ? depth_in : '0;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= rmfh_pkg::command_type'(req_command);
         tid_ff <= req_thread_id;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_thread = granted_ff;
   assign rsp_holder_valid   = holder_valid_ff;
   assign rsp_depth          = rsp_depth_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SlotCount)
      else $error("wait queue count exceeds the number of slots");

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_EXEC))
      else $error("result strobe without a decision cycle before it");

   a_free_is_clean: assert property (@(posedge clock) disable iff (reset)
      !present_ff |-> (depth_ff == '0) && (holder_ff == '0))
      else $error("free lock carries a holder or a depth");

   a_held_depth: assert property (@(posedge clock) disable iff (reset)
      present_ff |-> (depth_ff != '0))
      else $error("held lock has zero depth");
`endif

endmodule

// ===== sim/tb_recursive_mutex_fifo_handoff.sv =====
`timescale 1ns / 1ps

module tb_recursive_mutex_fifo_handoff;

   localparam int SLOTS       = rmfh_pkg::WAIT_SLOTS_DEFAULT;
   localparam int NEST_MAX    = rmfh_pkg::MAX_NEST_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      rmfh_pkg::status_type                 status;
      logic [rmfh_pkg::TID_W-1:0]   holder;
      logic                         held;
      logic [rmfh_pkg::DEPTH_W-1:0] depth;
   } lock_result_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_command;
   logic [rmfh_pkg::TID_W-1:0]    req_thread_id;
   logic                          rsp_valid;
   logic [rmfh_pkg::STATUS_W-1:0] rsp_status;
   logic [rmfh_pkg::TID_W-1:0]    rsp_granted_thread;
   logic                          rsp_holder_valid;
   logic [rmfh_pkg::DEPTH_W-1:0]  rsp_depth;
   logic                          csr_write_enable;
   logic                          csr_write_data;

   // Lock state as the testbench expects it to be after every accepted transaction.
   logic                         mode_recursive;
   logic                         lock_held;
   logic [rmfh_pkg::TID_W-1:0]   lock_owner;
   logic [rmfh_pkg::DEPTH_W-1:0] lock_depth;
   logic [rmfh_pkg::TID_W-1:0]   waiters[$];
   lock_result_type              pending_results[$];

   int                         mismatch_count = 0;
   int                         cycle_count = 0;
   int                         burst_left;
   bit                         gaps_on;
   logic [rmfh_pkg::TID_W-1:0] thread_pool[6];

   always #5 clock = ~clock;

   recursive_mutex_fifo_handoff u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_thread_id      (req_thread_id),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_granted_thread (rsp_granted_thread),
      .rsp_holder_valid   (rsp_holder_valid),
      .rsp_depth          (rsp_depth),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   function automatic void predict_lock(input rmfh_pkg::command_type cmd,
                                        input logic [rmfh_pkg::TID_W-1:0] tid);
      lock_result_type r;
      int              limit;
      limit = mode_recursive ? NEST_MAX : 1;
      if (cmd == rmfh_pkg::CMD_ACQUIRE) begin
         if (!lock_held) begin
            lock_held  = 1'b1;
            lock_owner = tid;
            lock_depth = rmfh_pkg::DEPTH_W'(1);
            r.status   = rmfh_pkg::ST_GRANTED;
         end else if (lock_owner == tid) begin
            if (lock_depth >= limit) begin
               r.status = rmfh_pkg::ST_DEPTH_ERR;
            end else begin
               lock_depth = lock_depth + 1'b1;
               r.status   = rmfh_pkg::ST_NESTED;
            end
         end else if (waiters.size() >= SLOTS) begin
            r.status = rmfh_pkg::ST_QUEUE_FULL;
         end else begin
            waiters.push_back(tid);
            r.status = rmfh_pkg::ST_QUEUED;
         end
      end else begin
         if (!lock_held || lock_owner != tid) begin
            r.status = rmfh_pkg::ST_NOT_HOLDER;
         end else if (lock_depth > 1) begin
            lock_depth = lock_depth - 1'b1;
            r.status   = rmfh_pkg::ST_UNNESTED;
         end else if (waiters.size() > 0) begin
            lock_owner = waiters.pop_front();
            lock_depth = rmfh_pkg::DEPTH_W'(1);
            r.status   = rmfh_pkg::ST_HANDOFF;
         end else begin
            lock_held  = 1'b0;
            lock_owner = '0;
            lock_depth = '0;
            r.status   = rmfh_pkg::ST_FREED;
         end
      end
      r.held   = lock_held;
      r.holder = lock_held ? lock_owner : '0;
      r.depth  = lock_held ? lock_depth : '0;
      pending_results.push_back(r);
   endfunction

   always @(posedge clock) begin : check_results
      lock_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d, thread %0d", rsp_status, rsp_granted_thread);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_granted_thread !== want.holder) begin
               $error("granted_thread: expected %0d, got %0d", want.holder, rsp_granted_thread);
               mismatch_count++;
            end
            if (rsp_holder_valid !== want.held) begin
               $error("holder_valid: expected %0d, got %0d", want.held, rsp_holder_valid);
               mismatch_count++;
            end
            if (rsp_depth !== want.depth) begin
               $error("depth: expected %0d, got %0d", want.depth, rsp_depth);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_recursive_mutex_fifo_handoff: done, errors");
         $finish;
      end
   end

   // Offers one command and returns once the block has taken the transaction.
   task automatic send_cmd(input rmfh_pkg::command_type cmd,
                           input logic [rmfh_pkg::TID_W-1:0] tid);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start         <= 1'b1;
      req_command   <= cmd;
      req_thread_id <= tid;
      do @(posedge clock); while (busy);
      predict_lock(cmd, tid);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic set_mode(input logic value);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      mode_recursive = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_free_lock_errors();
      set_mode(1'b0);
      send_cmd(rmfh_pkg::CMD_RELEASE, 8'h00);
      send_cmd(rmfh_pkg::CMD_RELEASE, 8'hFF);
      send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'h00);
      // Without recursion a second acquire by the holder is a depth error.
      send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'h00);
      send_cmd(rmfh_pkg::CMD_RELEASE, 8'hFF);
      send_cmd(rmfh_pkg::CMD_RELEASE, 8'h00);
      send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'hFF);
      send_cmd(rmfh_pkg::CMD_RELEASE, 8'hFF);
   endtask

   task automatic test_queue_full();
      set_mode(1'b0);
      send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'h5A);
      send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'h00);
      send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'hFF);
      // A thread that already waits is queued a second time.
      send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'h00);
      for (int i = 0; i < SLOTS - 3; i++) send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'(i * 17 + 3));
      send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'hA5);
      send_cmd(rmfh_pkg::CMD_RELEASE, 8'hFF);
      while (lock_held) send_cmd(rmfh_pkg::CMD_RELEASE, lock_owner);
   endtask

   task automatic test_mode_change_nested();
      set_mode(1'b1);
      repeat (3) send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'h3C);
      send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'hC3);
      // Dropping recursion while nested blocks deeper nesting but still unwinds.
      set_mode(1'b0);
      send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'h3C);
      repeat (3) send_cmd(rmfh_pkg::CMD_RELEASE, 8'h3C);
      send_cmd(rmfh_pkg::CMD_RELEASE, 8'hC3);
   endtask

   task automatic test_depth_limit();
      set_mode(1'b1);
      repeat (NEST_MAX + 1) send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'h81);
      send_cmd(rmfh_pkg::CMD_ACQUIRE, 8'h7E);
      repeat (NEST_MAX) send_cmd(rmfh_pkg::CMD_RELEASE, 8'h81);
      send_cmd(rmfh_pkg::CMD_RELEASE, 8'h7E);
   endtask

   // Mostly well-formed traffic from a small set of threads, with some random noise.
   task automatic test_random(input logic mode, input int items);
      int                         sent;
      int                         pick;
      int                         queue_weight;
      logic [rmfh_pkg::TID_W-1:0] tid;
      set_mode(mode);
      sent = 0;
      while (sent < items) begin
         if (sent % 60 == 0) begin
            foreach (thread_pool[i]) thread_pool[i] = 8'($urandom_range(0, 255));
            queue_weight = $urandom_range(10, 60);
            gaps_on = ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 99);
         tid  = thread_pool[$urandom_range(0, 5)];
         if (pick < 8)
            send_cmd(rmfh_pkg::command_type'($urandom_range(0, 1)), 8'($urandom));
         else if (!lock_held)
            send_cmd(rmfh_pkg::CMD_ACQUIRE, tid);
         else if (pick < 8 + queue_weight)
            send_cmd(rmfh_pkg::CMD_ACQUIRE, tid);
         else if (pick < 8 + queue_weight + 6)
            send_cmd(rmfh_pkg::CMD_RELEASE, tid);
         else
            send_cmd(rmfh_pkg::CMD_RELEASE, lock_owner);
         sent++;
      end
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_command      = rmfh_pkg::CMD_ACQUIRE;
      req_thread_id    = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      mode_recursive   = 1'b0;
      lock_held        = 1'b0;
      lock_owner       = '0;
      lock_depth       = '0;
      burst_left       = 0;
      gaps_on          = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_free_lock_errors();
      test_queue_full();
      test_mode_change_nested();
      test_depth_limit();
      test_random(1'b0, 250);
      test_random(1'b1, 250);
      test_random(1'b0, 220);
      test_random(1'b1, 220);

      drain();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb_recursive_mutex_fifo_handoff: done, clean");
      end else begin
         $display("tb_recursive_mutex_fifo_handoff: done, errors");
      end
      $finish;
   end

endmodule
